@@ sv/i2p_pkg.sv @@
// Shared types and constants for the infix-to-postfix operator stack.
// No dependencies; imported by every module of the block but i2p_ram.
package i2p_pkg;

    localparam int unsigned DEFAULT_STACK_DEPTH = 16;

    localparam int unsigned TAG_W   = 16;
    localparam int unsigned BASE_W  = 7;
    localparam int unsigned DOTS_W  = 4;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned ENTRY_W = TAG_W + PRIO_W;

    // Token kinds on input and output
    typedef enum logic [1:0] {
        KIND_OPERAND  = 2'd0,
        KIND_OPERATOR = 2'd1,
        KIND_RESERVED = 2'd2,
        KIND_END      = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WORK = 1'b1
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;   // capture the accepted token
        logic pop;         // move top of stack into the pending slot
        logic emit_pend;   // move the pending slot into the output register
        logic pend_last;   // pending result is the last one of this token
        logic emit_final;  // load operand / reserved word / end marker into output
        logic push;        // push the current operator (or flag overflow)
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_ok;      // top of stack must be popped for this token
        logic pend_valid;  // pending slot holds a popped operator
        logic out_free;    // output register can take a result this cycle
        logic is_operator; // current token is an operator keyword
    } status_t;

endpackage

@@ sv/i2p_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2p_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/i2p_ctrl.sv @@
// Sequencer for the operator stack: accepts a token, steps pops, then
// finishes the token. Depends on i2p_pkg.
module i2p_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  i2p_pkg::status_t  status,
    output i2p_pkg::cmd_t     cmd
);

    import i2p_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        done     = 1'b0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_WORK:
            begin
                priority if (status.pop_ok)
                begin
                    // pop needs room for the earlier pending result
                    if (!status.pend_valid || status.out_free)
                    begin
                        cmd.pop       = 1'b1;
                        cmd.emit_pend = status.pend_valid;
                    end
                end
                else if (status.is_operator)
                begin
                    if (!status.pend_valid || status.out_free)
                    begin
                        cmd.emit_pend = status.pend_valid;
                        cmd.pend_last = 1'b1;
                        cmd.push      = 1'b1;
                        done          = 1'b1;
                    end
                end
                else if (status.out_free)
                begin
                    if (status.pend_valid)
                    begin
                        cmd.emit_pend = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_final = 1'b1;
                        done           = 1'b1;
                    end
                end
                else
                begin
                    // hold until the result register drains
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/i2p_dp.sv @@
// Datapath: token register, operator stack (cached top plus RAM), pending
// slot and output register. Depends on i2p_pkg and i2p_ram.
module i2p_dp #(
    parameter int unsigned STACK_DEPTH = i2p_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  i2p_pkg::cmd_t               cmd,
    output i2p_pkg::status_t            status,
    input  i2p_pkg::kind_t              in_kind,
    input  logic [i2p_pkg::BASE_W-1:0]  in_base,
    input  logic [i2p_pkg::DOTS_W-1:0]  in_dots,
    input  logic [i2p_pkg::TAG_W-1:0]   in_tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [i2p_pkg::TAG_W-1:0]   out_tag,
    output i2p_pkg::kind_t              out_kind,
    output logic                        out_ovf,
    output logic                        out_last
);

    import i2p_pkg::*;

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

    // Current token
    kind_t               kind_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic [TAG_W-1:0]    tag_reg;

    // Stack: top entry in flops, the rest in RAM below it
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [TAG_W-1:0]    top_tag_reg;
    logic [PRIO_W-1:0]   top_prio_reg;
    logic                ovf_reg;

    // Pending popped operator, held until it is known whether it is last
    logic                pend_valid_reg;
    logic [TAG_W-1:0]    pend_tag_reg;

    // Output register
    logic                out_valid_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    kind_t               out_kind_reg;
    logic                out_ovf_reg;
    logic                out_last_reg;

    logic                push_ok;
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;
    logic [CNT_W-1:0]    rd_cnt;
    logic [PRIO_W-1:0]   in_prio;
    logic                out_free;

    assign in_prio  = (in_kind == KIND_OPERATOR)
                    ? (PRIO_W'(in_base) + PRIO_W'(in_dots))
                    : PRIO_W'(in_base);
    assign out_free = !out_valid_reg || out_ready;
    assign push_ok  = cmd.push && (count_reg < CNT_W'(STACK_DEPTH));

    always_comb
    begin
        status.out_free    = out_free;
        status.pend_valid  = pend_valid_reg;
        status.is_operator = (kind_reg == KIND_OPERATOR);
        status.pop_ok      = (count_reg != '0) && (kind_reg != KIND_OPERAND)
                           && ((kind_reg == KIND_END) || (top_prio_reg >= prio_reg));
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (push_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Keep the entry just below the top on the RAM read port
    assign rd_cnt      = count_next - CNT_W'(2);
    assign ram_wr_en   = push_ok && (count_reg != '0);
    assign ram_wr_addr = IDX_W'(count_reg - CNT_W'(1));

    i2p_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data ({top_prio_reg, top_tag_reg}),
        .rd_addr (rd_cnt[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= in_kind;
            prio_reg <= in_prio;
            tag_reg  <= in_tag;
        end
        if (cmd.pop)
        begin
            top_prio_reg <= ram_rd_data[ENTRY_W-1:TAG_W];
            top_tag_reg  <= ram_rd_data[TAG_W-1:0];
            pend_tag_reg <= top_tag_reg;
        end
        else if (push_ok)
        begin
            top_prio_reg <= prio_reg;
            top_tag_reg  <= tag_reg;
        end
        if (cmd.emit_pend)
        begin
            out_tag_reg  <= pend_tag_reg;
            out_kind_reg <= KIND_OPERATOR;
            out_ovf_reg  <= 1'b0;
            out_last_reg <= cmd.pend_last;
        end
        else if (cmd.emit_final)
        begin
            out_tag_reg  <= (kind_reg == KIND_END) ? '0 : tag_reg;
            out_kind_reg <= kind_reg;
            out_ovf_reg  <= (kind_reg == KIND_END) ? ovf_reg : 1'b0;
            out_last_reg <= 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.push && !push_ok)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.pop)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.emit_pend)
            begin
                pend_valid_reg <= 1'b0;
            end
            out_valid_reg <= (out_valid_reg && !out_ready) || cmd.emit_pend
                           || cmd.emit_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_kind  = out_kind_reg;
    assign out_ovf   = out_ovf_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (count_reg != '0))
        else $error("pop from empty stack");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_pend || cmd.emit_final) |-> out_free)
        else $error("result overwrites an untaken result");

    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |-> !pend_valid_reg)
        else $error("new token while a popped operator is pending");
`endif

endmodule

@@ sv/infix_to_postfix_operator_stack.sv @@
// Top level of the infix-to-postfix operator stack (shunting yard).
// Depends on i2p_pkg, i2p_ctrl, i2p_dp (which holds i2p_ram).
//
//  Channel   | Signals                                    | Direction
//  ----------+--------------------------------------------+----------
//  token in  | s_axis_tvalid/tready, tdata[31:0], tuser   | input
//  result out| m_axis_tvalid/tready, tdata[15:0], tuser,  | output
//            | tlast                                      |
//
// A token is accepted, then each popped operator is handled in turn and a
// finishing step ends it; a reserved word or end of line that popped
// anything takes an extra step to release the last popped operator.
// Pops run one per cycle, bounded by the single RAM read port feeding the
// cached top of stack. A stalled result output holds the sequencer in place.
// Reset clears stack count, overflow flag and all handshake state at once;
// stack contents need no clearing.
module infix_to_postfix_operator_stack #(
    parameter int unsigned STACK_DEPTH = i2p_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // Token input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [6:0] base_priority, [10:7] dot_count,
                                        // [26:11] tag, [31:27] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_tag
    output logic [2:0]  m_axis_tuser,   // [1:0] out_kind, [2] overflow_seen
    output logic        m_axis_tlast    // last result for the token
);

    import i2p_pkg::*;

    cmd_t    cmd;
    status_t status;
    kind_t   in_kind;
    kind_t   out_kind;
    logic    out_ovf;

    // Unpack the token transfer
    assign in_kind = kind_t'(s_axis_tuser);

    i2p_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    i2p_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_kind   (in_kind),
        .in_base   (s_axis_tdata[6:0]),
        .in_dots   (s_axis_tdata[10:7]),
        .in_tag    (s_axis_tdata[26:11]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tag   (m_axis_tdata),
        .out_kind  (out_kind),
        .out_ovf   (out_ovf),
        .out_last  (m_axis_tlast)
    );

    // Pack the result sideband
    assign m_axis_tuser = {out_ovf, out_kind};

endmodule
